// ===== rtl/postfix_expression_evaluator_unit_defines.svh =====
// Assertion helpers for the postfix evaluator.
// Clock i_clk and reset i_rst_n must be visible where these are used.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_UNIT_DEFINES_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define PFX_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PFX_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/pfx_pkg.sv =====
package pfx_pkg;

    // data format: signed Q16.16
    localparam int DATA_W = 32;
    localparam int FRAC_W = 16;

    // operand stack
    localparam int STACK_DEPTH = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);

    // divider iterations: quotient bits 32..0
    localparam int DIV_CNT_W = $clog2(DATA_W + 1);

    localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // character codes
    localparam logic [7:0] CHAR_ZERO = 8'd48;
    localparam logic [7:0] CHAR_NINE = 8'd57;
    localparam logic [7:0] CHAR_ADD  = 8'd43;
    localparam logic [7:0] CHAR_SUB  = 8'd45;
    localparam logic [7:0] CHAR_MUL  = 8'd42;
    localparam logic [7:0] CHAR_DIV  = 8'd47;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DIV0  = 2'd1,
        ST_UNDER = 2'd2,
        ST_OVER  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_alu_op;

    // stack memory port request
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } t_stk_req;

endpackage

// ===== rtl/pfx_stack.sv =====
module pfx_stack (
    input  logic                        i_clk,
    input  pfx_pkg::t_stk_req           i_req,
    output logic [pfx_pkg::DATA_W-1:0]  o_rdata
);

    logic [pfx_pkg::DATA_W-1:0] r_mem [pfx_pkg::STACK_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.raddr];
    end

endmodule

// ===== rtl/pfx_alu.sv =====
module pfx_alu (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  pfx_pkg::t_alu_op                   i_op,
    input  logic signed [pfx_pkg::DATA_W-1:0]  i_a,
    input  logic signed [pfx_pkg::DATA_W-1:0]  i_b,
    output logic                               o_done,
    output logic [pfx_pkg::DATA_W-1:0]         o_result
);

    localparam int W  = pfx_pkg::DATA_W;
    localparam int FW = pfx_pkg::FRAC_W;

    typedef enum logic [1:0] {A_IDLE, A_MUL, A_DIV, A_DFIN} t_state;

    t_state                       r_state;
    logic                         r_done;
    logic [W-1:0]                 r_res;
    logic signed [2*W-1:0]        r_prod;
    logic [W-1:0]                 r_rem;
    logic [W-1:0]                 r_dsr;
    logic [W:0]                   r_dvd;
    logic [W:0]                   r_quo;
    logic [pfx_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                         r_neg;

    logic [W:0]      sum_ext, diff_ext;
    logic [W-1:0]    mag_a, mag_b;
    logic            div_ovf;
    logic [W:0]      rem_sh;
    logic            rem_ge;
    logic [W-1:0]    n_rem;
    logic [2*W-1:0]  prod_sh;
    logic [W-1:0]    mul_sat;
    logic [W-1:0]    n_div_res;
    logic [W:0]      quo_neg;

    function automatic logic [W-1:0] sat_ext(input logic [W:0] v);
        logic [W-1:0] r;
        if (v[W] != v[W-1]) begin
            r = v[W] ? pfx_pkg::SAT_MIN : pfx_pkg::SAT_MAX;
        end else begin
            r = v[W-1:0];
        end
        return r;
    endfunction

    always_comb begin
        sum_ext  = {i_b[W-1], i_b} + {i_a[W-1], i_a};
        diff_ext = {i_b[W-1], i_b} - {i_a[W-1], i_a};
        mag_a    = i_a[W-1] ? (W'(0) - i_a) : i_a;
        mag_b    = i_b[W-1] ? (W'(0) - i_b) : i_b;
        // dividend is |b| << 16; quotient fits 33 bits iff |b| >> 17 < |a|
        div_ovf  = (mag_b >> (FW + 1)) >= mag_a;

        rem_sh = {r_rem, r_dvd[W]};
        rem_ge = rem_sh >= {1'b0, r_dsr};
        n_rem  = rem_ge ? W'(rem_sh - {1'b0, r_dsr}) : rem_sh[W-1:0];

        // arithmetic shift = floor toward minus infinity
        prod_sh = r_prod >>> FW;
        if ((&prod_sh[2*W-1:W-1]) || !(|prod_sh[2*W-1:W-1])) begin
            mul_sat = prod_sh[W-1:0];
        end else begin
            mul_sat = prod_sh[2*W-1] ? pfx_pkg::SAT_MIN : pfx_pkg::SAT_MAX;
        end

        quo_neg = (W+1)'(0) - r_quo;
        if (!r_neg) begin
            n_div_res = (r_quo > {1'b0, pfx_pkg::SAT_MAX}) ? pfx_pkg::SAT_MAX : r_quo[W-1:0];
        end else begin
            n_div_res = (r_quo > {1'b0, pfx_pkg::SAT_MIN}) ? pfx_pkg::SAT_MIN : quo_neg[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done  <= 1'b0;
        end else begin
            case (r_state)
                A_IDLE: begin
                    if (i_start) begin
                        case (i_op)
                            pfx_pkg::OP_ADD: begin
                                r_res  <= sat_ext(sum_ext);
                                r_done <= 1'b1;
                            end
                            pfx_pkg::OP_SUB: begin
                                r_res  <= sat_ext(diff_ext);
                                r_done <= 1'b1;
                            end
                            pfx_pkg::OP_MUL: begin
                                r_prod  <= (2*W)'(i_a) * (2*W)'(i_b);
                                r_done  <= 1'b0;
                                r_state <= A_MUL;
                            end
                            pfx_pkg::OP_DIV: begin
                                r_neg <= i_a[W-1] ^ i_b[W-1];
                                if (div_ovf) begin
                                    r_res  <= (i_a[W-1] ^ i_b[W-1]) ? pfx_pkg::SAT_MIN
                                                                    : pfx_pkg::SAT_MAX;
                                    r_done <= 1'b1;
                                end else begin
                                    r_rem   <= W'(mag_b >> (FW + 1));
                                    r_dvd   <= {mag_b[FW:0], {FW{1'b0}}};
                                    r_dsr   <= mag_a;
                                    r_quo   <= '0;
                                    r_cnt   <= pfx_pkg::DIV_CNT_W'(W);
                                    r_done  <= 1'b0;
                                    r_state <= A_DIV;
                                end
                            end
                            default: begin
                                r_done  <= 1'b0;
                                r_state <= A_IDLE;
                            end
                        endcase
                    end else begin
                        r_done <= 1'b0;
                    end
                end
                A_MUL: begin
                    r_res   <= mul_sat;
                    r_done  <= 1'b1;
                    r_state <= A_IDLE;
                end
                A_DIV: begin
                    // one quotient bit per cycle
                    r_done <= 1'b0;
                    r_rem  <= n_rem;
                    r_dvd  <= {r_dvd[W-1:0], 1'b0};
                    r_quo  <= {r_quo[W-1:0], rem_ge};
                    r_cnt  <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= A_DFIN;
                    end
                end
                A_DFIN: begin
                    r_res   <= n_div_res;
                    r_done  <= 1'b1;
                    r_state <= A_IDLE;
                end
                default: begin
                    r_done  <= 1'b0;
                    r_state <= A_IDLE;
                end
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

// ===== rtl/postfix_expression_evaluator_unit.sv =====
// Postfix expression evaluator, one ASCII character per input word.
// Input channel s_axis: tdata[7:0] = symbol, tlast = last character of
// the expression. Digits '0'..'9' push value << 16 (signed Q16.16);
// '+', '-', '*', '/' pop a (top) and b and push b op a, saturated; any
// other character pops both and pushes nothing.
// Output channel m_axis: one word per input word. tdata = top of stack
// after the step (0 if empty), tuser = status (0 ok, 1 divide by zero,
// 2 underflow, 3 overflow), tlast = copy of the input tlast. After a word
// marked last the stack is emptied.
// Each word passes S_DECODE; an operator or unknown character with two
// operands on the stack then passes S_LOAD_A, S_LOAD_B and, except for an
// unknown character or a divide by zero, S_EXEC. Every word ends with
// S_TOP_RD, S_TOP_CAP and S_FINISH. A divide in S_EXEC waits on the shared
// arithmetic unit, which produces one quotient bit per cycle over 33 bits.
// One word is in work at a time; s_axis_tready is high only while idle.
// The result sits in an output register, so a new word is accepted while
// the previous result waits for m_axis_tready. If that register is still
// full when the next result is ready, the sequencer waits.
// Reset (i_rst_n low, synchronous) empties the stack and drops any pending
// result; stack memory contents are not cleared and need no clearing.
`include "postfix_expression_evaluator_unit_defines.svh"

module postfix_expression_evaluator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] symbol
    input  logic        s_axis_tlast,   // last_symbol
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] top_value
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    output logic        m_axis_tlast    // expression_done
);

    localparam int W  = pfx_pkg::DATA_W;
    localparam int AW = pfx_pkg::ADDR_W;
    localparam int CW = pfx_pkg::CNT_W;

    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_LOAD_A, S_LOAD_B, S_EXEC, S_TOP_RD, S_TOP_CAP, S_FINISH
    } t_state;

    t_state            r_state;
    logic [7:0]        r_sym;
    logic              r_last;
    logic [CW-1:0]     r_count;
    logic [W-1:0]      r_a;
    logic [W-1:0]      r_top;
    pfx_pkg::t_status  r_status;
    logic              r_m_valid;
    logic [W-1:0]      r_m_data;
    pfx_pkg::t_status  r_m_user;
    logic              r_m_last;

    pfx_pkg::t_stk_req stk_req;
    logic [W-1:0]      stk_rdata;

    logic              alu_start;
    pfx_pkg::t_alu_op  alu_op;
    logic              alu_done;
    logic [W-1:0]      alu_result;

    logic              is_digit;
    logic              is_op;
    logic [3:0]        digit;
    logic [W-1:0]      digit_val;
    logic [CW-1:0]     cnt_m1, cnt_m2;

    // ---- decode of the held symbol ----
    always_comb begin
        is_digit  = (r_sym >= pfx_pkg::CHAR_ZERO) && (r_sym <= pfx_pkg::CHAR_NINE);
        digit     = 4'(r_sym - pfx_pkg::CHAR_ZERO);
        digit_val = {{(W-4-pfx_pkg::FRAC_W){1'b0}}, digit, {pfx_pkg::FRAC_W{1'b0}}};
        is_op     = 1'b1;
        case (r_sym)
            pfx_pkg::CHAR_ADD: alu_op = pfx_pkg::OP_ADD;
            pfx_pkg::CHAR_SUB: alu_op = pfx_pkg::OP_SUB;
            pfx_pkg::CHAR_MUL: alu_op = pfx_pkg::OP_MUL;
            pfx_pkg::CHAR_DIV: alu_op = pfx_pkg::OP_DIV;
            default: begin
                alu_op = pfx_pkg::OP_ADD;
                is_op  = 1'b0;
            end
        endcase
        cnt_m1 = r_count - 1'b1;
        cnt_m2 = r_count - CW'(2);
    end

    // ---- stack port: one write and one registered read per cycle ----
    always_comb begin
        stk_req.we    = 1'b0;
        stk_req.waddr = r_count[AW-1:0];
        stk_req.wdata = alu_result;
        stk_req.raddr = cnt_m1[AW-1:0];
        case (r_state)
            S_DECODE: begin
                if (is_digit && r_count < CW'(pfx_pkg::STACK_DEPTH)) begin
                    stk_req.we    = 1'b1;
                    stk_req.wdata = digit_val;
                end
            end
            S_LOAD_A: stk_req.raddr = cnt_m2[AW-1:0];
            S_EXEC:   stk_req.we    = alu_done;
            default:  stk_req.we    = 1'b0;
        endcase
    end

    // start the shared unit once both operands are in; divide by zero skips it
    assign alu_start = (r_state == S_LOAD_B) && is_op &&
                       !(alu_op == pfx_pkg::OP_DIV && r_a == '0);

    pfx_stack u_stack (
        .i_clk   (i_clk),
        .i_req   (stk_req),
        .o_rdata (stk_rdata)
    );

    pfx_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (alu_start),
        .i_op     (alu_op),
        .i_a      (r_a),
        .i_b      (stk_rdata),
        .o_done   (alu_done),
        .o_result (alu_result)
    );

    // ---- sequencer and output register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            // finish state owns the valid flag while it loads a word
            if (m_axis_tready && r_state != S_FINISH) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_sym   <= s_axis_tdata;
                        r_last  <= s_axis_tlast;
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    if (is_digit) begin
                        if (r_count >= CW'(pfx_pkg::STACK_DEPTH)) begin
                            r_status <= pfx_pkg::ST_OVER;
                        end else begin
                            r_status <= pfx_pkg::ST_OK;
                            r_count  <= r_count + 1'b1;
                        end
                        r_state <= S_TOP_RD;
                    end else if (r_count < CW'(2)) begin
                        r_status <= pfx_pkg::ST_UNDER;
                        r_state  <= S_TOP_RD;
                    end else begin
                        r_status <= pfx_pkg::ST_OK;
                        r_state  <= S_LOAD_A;
                    end
                end
                S_LOAD_A: begin
                    r_a     <= stk_rdata;
                    r_state <= S_LOAD_B;
                end
                S_LOAD_B: begin
                    r_count <= cnt_m2;
                    if (is_op && alu_op == pfx_pkg::OP_DIV && r_a == '0) begin
                        r_status <= pfx_pkg::ST_DIV0;
                    end
                    r_state <= alu_start ? S_EXEC : S_TOP_RD;
                end
                S_EXEC: begin
                    if (alu_done) begin
                        r_count <= r_count + 1'b1;
                        r_state <= S_TOP_RD;
                    end
                end
                S_TOP_RD: begin
                    r_state <= S_TOP_CAP;
                end
                S_TOP_CAP: begin
                    r_top   <= (r_count == '0) ? '0 : stk_rdata;
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (!r_m_valid || m_axis_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= r_top;
                        r_m_user  <= r_status;
                        r_m_last  <= r_last;
                        if (r_last) begin
                            r_count <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;
    assign m_axis_tlast  = r_m_last;

    // ---- checks ----
    `PFX_ASSERT_IMP(a_count_range, 1'b1, r_count <= CW'(pfx_pkg::STACK_DEPTH), "stack count beyond depth")
    `PFX_ASSERT_IMP(a_alu_done_exec, alu_done, r_state == S_EXEC, "arithmetic result outside execute")
    `PFX_ASSERT_NXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second word taken while busy")
    `PFX_ASSERT_IMP(a_out_from_finish, $rose(r_m_valid), $past(r_state == S_FINISH), "result loaded outside finish")

endmodule
